>>> src/bcpr_pkg.sv
// Package for the banded current PWM regulator: field widths, payload
// structs, register indexes and regulation thresholds.
// No dependencies.
package bcpr_pkg;

  // Field widths
  localparam int unsigned SampleBits = 12;
  localparam int unsigned DutyBits   = 16;
  localparam int unsigned PeriodBits = 8;
  localparam int unsigned CfgIdxBits = 8;
  localparam int unsigned CfgDatBits = 16;

  // Compare width: holds every sample and every threshold
  localparam int unsigned CmpBits = 17;

  typedef logic [CmpBits-1:0] cmp_t;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegEnable      = 8'd0;
  localparam logic [CfgIdxBits-1:0] RegStepPeriod  = 8'd1;
  localparam logic [CfgIdxBits-1:0] RegDutyMax     = 8'd2;
  localparam logic [CfgIdxBits-1:0] RegDutyInitial = 8'd3;

  // Register reset values
  localparam logic [PeriodBits-1:0] StepPeriodRst  = 8'd10;
  localparam logic [DutyBits-1:0]   DutyMaxRst     = 16'd1000;
  localparam logic [DutyBits-1:0]   DutyInitialRst = 16'd0;

  // Voltage band edges
  localparam cmp_t VoltBandLow  = 17'd150;
  localparam cmp_t VoltBandHigh = 17'd250;

  // Current windows per band
  localparam cmp_t AmpLoBand0 = 17'd210;
  localparam cmp_t AmpHiBand0 = 17'd230;
  localparam cmp_t AmpLoBand1 = 17'd300;
  localparam cmp_t AmpHiBand1 = 17'd320;
  localparam cmp_t AmpLoBand2 = 17'd340;
  localparam cmp_t AmpHiBand2 = 17'd360;

  // Overcurrent cut level at zero duty
  localparam cmp_t AmpCutLevel = 17'd600;

  typedef struct packed {
    logic [SampleBits-1:0] volt_sample;
    logic [SampleBits-1:0] amp_sample;
  } in_item_t;

  typedef struct packed {
    logic                power_on;
    logic                pwm_running;
    logic [DutyBits-1:0] duty;
    logic                step_done;
  } out_item_t;

endpackage

>>> src/banded_current_pwm_regulator_core.sv
// Banded current PWM regulator core: tick prescaler, band/window select,
// duty up/down stepping and power cut. Depends on bcpr_pkg.
//
// Path: a transferred tick is captured in the input register, then the
// regulation logic writes its result into the result register.
// Throughput: one tick per cycle; the input register refills whenever the
// result register is empty or being taken downstream.
// Reset: asynchronous, active low; clears prescaler, duty, power and PWM
// flags and loads the configuration registers with their defaults.
module banded_current_pwm_regulator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Tick input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bcpr_pkg::in_item_t             in_data_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bcpr_pkg::out_item_t            out_data_o,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bcpr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [bcpr_pkg::CfgDatBits-1:0] cfg_data_i
);

  // Configuration registers
  logic                              enable_q;
  logic [bcpr_pkg::PeriodBits-1:0]   step_period_q;
  logic [bcpr_pkg::DutyBits-1:0]     duty_max_q;
  logic [bcpr_pkg::DutyBits-1:0]     duty_initial_q;

  // Regulator state
  logic [bcpr_pkg::PeriodBits-1:0]   tick_q, tick_d;
  logic [bcpr_pkg::DutyBits-1:0]     duty_q, duty_d;
  logic                              power_q, power_d;
  logic                              pwm_q, pwm_d;
  logic                              done_d;

  // Pipeline registers
  logic                              in_valid_q;
  bcpr_pkg::in_item_t                in_item_q;
  logic                              out_valid_q;
  bcpr_pkg::out_item_t               out_item_q;

  logic                              in_xfer;
  logic                              advance;
  bcpr_pkg::cmp_t                    volt;
  bcpr_pkg::cmp_t                    amp;
  bcpr_pkg::cmp_t                    win_lo;
  bcpr_pkg::cmp_t                    win_hi;
  logic [bcpr_pkg::DutyBits-1:0]     duty_up;

  // Handshake: stage 1 moves on when the result slot is free or emptying
  assign advance     = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  // Configuration writes, truncated to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      step_period_q  <= bcpr_pkg::StepPeriodRst;
      duty_max_q     <= bcpr_pkg::DutyMaxRst;
      duty_initial_q <= bcpr_pkg::DutyInitialRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bcpr_pkg::RegEnable:      enable_q       <= cfg_data_i[0];
        bcpr_pkg::RegStepPeriod:  step_period_q  <= cfg_data_i[bcpr_pkg::PeriodBits-1:0];
        bcpr_pkg::RegDutyMax:     duty_max_q     <= cfg_data_i[bcpr_pkg::DutyBits-1:0];
        bcpr_pkg::RegDutyInitial: duty_initial_q <= cfg_data_i[bcpr_pkg::DutyBits-1:0];
        default: ;
      endcase
    end
  end

  // Samples widened for threshold compares
  assign volt = bcpr_pkg::cmp_t'(in_item_q.volt_sample);
  assign amp  = bcpr_pkg::cmp_t'(in_item_q.amp_sample);

  // Voltage band picks the current window
  always_comb begin
    if (volt < bcpr_pkg::VoltBandLow) begin
      win_lo = bcpr_pkg::AmpLoBand0;
      win_hi = bcpr_pkg::AmpHiBand0;
    end else if (volt < bcpr_pkg::VoltBandHigh) begin
      win_lo = bcpr_pkg::AmpLoBand1;
      win_hi = bcpr_pkg::AmpHiBand1;
    end else begin
      win_lo = bcpr_pkg::AmpLoBand2;
      win_hi = bcpr_pkg::AmpHiBand2;
    end
  end

  // Prescaler and control step
  always_comb begin
    tick_d  = tick_q;
    duty_d  = duty_q;
    power_d = power_q;
    pwm_d   = pwm_q;
    done_d  = 1'b0;
    duty_up = duty_q;

    if (tick_q < step_period_q) begin
      tick_d = tick_q + 1'b1;
    end

    if (tick_d >= step_period_q) begin
      tick_d = '0;
      done_d = 1'b1;
      if (!enable_q) begin
        power_d = 1'b0;
        pwm_d   = 1'b0;
        duty_d  = duty_initial_q;
      end else begin
        power_d = 1'b1;
        pwm_d   = 1'b1;
        // count up below the window, saturating at duty_max
        if (amp < win_lo && duty_q < duty_max_q) begin
          duty_up = duty_q + 1'b1;
        end
        duty_d = duty_up;
        // count down above the window, saturating at zero
        if (amp > win_hi && duty_up != '0) begin
          duty_d = duty_up - 1'b1;
        end
        // overcurrent at zero duty: cut power until next step
        if (duty_d == '0 && amp > bcpr_pkg::AmpCutLevel) begin
          power_d = 1'b0;
        end
      end
    end
  end

  // Regulator state, updated once per processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      duty_q  <= bcpr_pkg::DutyInitialRst;
      power_q <= 1'b0;
      pwm_q   <= 1'b0;
    end else if (advance) begin
      tick_q  <= tick_d;
      duty_q  <= duty_d;
      power_q <= power_d;
      pwm_q   <= pwm_d;
    end
  end

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_data_i;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.power_on    <= power_d;
      out_item_q.pwm_running <= pwm_d;
      out_item_q.duty        <= duty_d;
      out_item_q.step_done   <= done_d;
    end
  end

endmodule

>>> tb/sv/banded_current_pwm_regulator_core_tb.sv
// Testbench for banded_current_pwm_regulator_core: directed and random ticks checked against
// a cycle-free model of prescaler, band windows, duty stepping and power cut.
// Depends on bcpr_pkg and the core; needs no files or arguments.
module banded_current_pwm_regulator_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Band edges, current windows and cut level of the regulator
  localparam int unsigned BandEdge0 = 150;
  localparam int unsigned BandEdge1 = 250;
  localparam int unsigned WinLo0    = 210;
  localparam int unsigned WinHi0    = 230;
  localparam int unsigned WinLo1    = 300;
  localparam int unsigned WinHi1    = 320;
  localparam int unsigned WinLo2    = 340;
  localparam int unsigned WinHi2    = 360;
  localparam int unsigned CutAmp    = 600;
  localparam int unsigned MaxSample = (1 << bcpr_pkg::SampleBits) - 1;

  localparam int unsigned RandPhases    = 15;
  localparam int unsigned TicksPerPhase = 110;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            in_valid    = 1'b0;
  logic                            in_stall;
  bcpr_pkg::in_item_t              in_data     = '0;
  logic                            out_valid;
  logic                            out_stall   = 1'b0;
  bcpr_pkg::out_item_t             out_data;
  logic                            cfg_valid   = 1'b0;
  logic                            cfg_ready;
  logic [bcpr_pkg::CfgIdxBits-1:0] cfg_index   = '0;
  logic [bcpr_pkg::CfgDatBits-1:0] cfg_data    = '0;

  // Model copy of registers and regulator state
  logic                            mdl_enable    = 1'b0;
  logic [bcpr_pkg::PeriodBits-1:0] mdl_period    = 8'd10;
  logic [bcpr_pkg::DutyBits-1:0]   mdl_duty_max  = 16'd1000;
  logic [bcpr_pkg::DutyBits-1:0]   mdl_duty_init = 16'd0;
  logic [bcpr_pkg::PeriodBits-1:0] mdl_ticks     = '0;
  logic [bcpr_pkg::DutyBits-1:0]   mdl_duty      = '0;
  logic                            mdl_power     = 1'b0;
  logic                            mdl_pwm       = 1'b0;

  bcpr_pkg::out_item_t regulator_out_q[$];
  int unsigned         mismatch_cnt  = 0;
  logic                in_gaps_on    = 1'b1;
  logic                out_stalls_on = 1'b1;
  int unsigned         stall_left    = 0;

  banded_current_pwm_regulator_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One tick of the regulator: prescaler, then a control step when it fires
  function automatic bcpr_pkg::out_item_t regulate_tick(bcpr_pkg::in_item_t t);
    bcpr_pkg::out_item_t o;
    int unsigned         volt, amp, lo, hi;
    logic                done;
    volt = 32'(t.volt_sample);
    amp  = 32'(t.amp_sample);
    done = 1'b0;
    if (mdl_ticks < mdl_period) mdl_ticks = mdl_ticks + 8'd1;
    if (mdl_ticks >= mdl_period) begin
      mdl_ticks = '0;
      done      = 1'b1;
      if (!mdl_enable) begin
        mdl_power = 1'b0;
        mdl_pwm   = 1'b0;
        mdl_duty  = mdl_duty_init;
      end else begin
        mdl_power = 1'b1;
        mdl_pwm   = 1'b1;
        if (volt < BandEdge0) begin
          lo = WinLo0; hi = WinHi0;
        end else if (volt < BandEdge1) begin
          lo = WinLo1; hi = WinHi1;
        end else begin
          lo = WinLo2; hi = WinHi2;
        end
        if (amp < lo && mdl_duty < mdl_duty_max) mdl_duty = mdl_duty + 16'd1;
        if (amp > hi && mdl_duty > 0) mdl_duty = mdl_duty - 16'd1;
        if (mdl_duty == 0 && amp > CutAmp) mdl_power = 1'b0;
      end
    end
    o.power_on    = mdl_power;
    o.pwm_running = mdl_pwm;
    o.duty        = mdl_duty;
    o.step_done   = done;
    return o;
  endfunction

  // Random tick: mostly samples placed around a band window, some pure noise
  function automatic bcpr_pkg::in_item_t pick_tick();
    bcpr_pkg::in_item_t t;
    int unsigned        band, lo, hi, r;
    if ($urandom_range(0, 99) < 20) begin
      t.volt_sample = bcpr_pkg::SampleBits'($urandom_range(0, MaxSample));
      t.amp_sample  = bcpr_pkg::SampleBits'($urandom_range(0, MaxSample));
      return t;
    end
    band = $urandom_range(0, 2);
    case (band)
      0: begin
        t.volt_sample = bcpr_pkg::SampleBits'($urandom_range(0, BandEdge0 - 1));
        lo = WinLo0; hi = WinHi0;
      end
      1: begin
        t.volt_sample = bcpr_pkg::SampleBits'($urandom_range(BandEdge0, BandEdge1 - 1));
        lo = WinLo1; hi = WinHi1;
      end
      default: begin
        t.volt_sample = bcpr_pkg::SampleBits'($urandom_range(BandEdge1,
                          ($urandom_range(0, 3) == 0) ? MaxSample : 400));
        lo = WinLo2; hi = WinHi2;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < 45)
      t.amp_sample = bcpr_pkg::SampleBits'($urandom_range(lo - 4, hi + 4));
    else if (r < 55)
      t.amp_sample = bcpr_pkg::SampleBits'($urandom_range(CutAmp - 2, CutAmp + 2));
    else if (r < 70)
      t.amp_sample = bcpr_pkg::SampleBits'($urandom_range(CutAmp + 1, MaxSample));
    else if (r < 88)
      t.amp_sample = bcpr_pkg::SampleBits'($urandom_range(0, lo));
    else
      t.amp_sample = bcpr_pkg::SampleBits'($urandom_range(hi, MaxSample));
    return t;
  endfunction

  // Result stall generator
  always @(posedge clk) begin
    if (!out_stalls_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // Monitor: check results, track register writes, predict accepted ticks
  always @(posedge clk) begin
    bcpr_pkg::out_item_t exp_o;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (regulator_out_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("ERROR: unexpected result %p at %0t", out_data, $realtime);
          mismatch_cnt++;
        end else begin
          exp_o = regulator_out_q.pop_front();
          if (out_data.power_on !== exp_o.power_on ||
              out_data.pwm_running !== exp_o.pwm_running ||
              out_data.duty !== exp_o.duty || out_data.step_done !== exp_o.step_done) begin
            if (mismatch_cnt < 10)
              $display({"ERROR: result differs at %0t: exp pwr=%0d pwm=%0d duty=%0d step=%0d,",
                        " got pwr=%0d pwm=%0d duty=%0d step=%0d"},
                       $realtime, exp_o.power_on, exp_o.pwm_running, exp_o.duty,
                       exp_o.step_done, out_data.power_on, out_data.pwm_running,
                       out_data.duty, out_data.step_done);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bcpr_pkg::RegEnable:      mdl_enable    = cfg_data[0];
          bcpr_pkg::RegStepPeriod:  mdl_period    = cfg_data[bcpr_pkg::PeriodBits-1:0];
          bcpr_pkg::RegDutyMax:     mdl_duty_max  = cfg_data;
          bcpr_pkg::RegDutyInitial: mdl_duty_init = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) regulator_out_q.push_back(regulate_tick(in_data));
    end
  end

  // One tick transfer; valid stays high when the next tick follows without a gap
  task automatic send_tick(input logic [bcpr_pkg::SampleBits-1:0] volt,
                           input logic [bcpr_pkg::SampleBits-1:0] amp);
    int unsigned gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data.volt_sample <= volt;
    in_data.amp_sample  <= amp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (regulator_out_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write; valid is left high for a following write
  task automatic write_reg(input logic [bcpr_pkg::CfgIdxBits-1:0] idx,
                           input logic [bcpr_pkg::CfgDatBits-1:0] dat);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dat;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Full register setting; unused upper bits carry random junk
  task automatic set_regs(input logic en, input logic [bcpr_pkg::PeriodBits-1:0] per,
                          input logic [bcpr_pkg::DutyBits-1:0] dmax,
                          input logic [bcpr_pkg::DutyBits-1:0] dinit);
    wait_idle();
    write_reg(bcpr_pkg::RegEnable, {15'($urandom), en});
    write_reg(bcpr_pkg::RegStepPeriod, {8'($urandom), per});
    write_reg(bcpr_pkg::RegDutyMax, dmax);
    write_reg(bcpr_pkg::RegDutyInitial, dinit);
    cfg_valid <= 1'b0;
  endtask

  // Defaults after reset: disabled, step on the tenth tick
  task automatic test_reset_defaults();
    repeat (10) send_tick(bcpr_pkg::SampleBits'($urandom_range(0, MaxSample)),
                          bcpr_pkg::SampleBits'($urandom_range(0, MaxSample)));
  endtask

  // Each band and the edges of its current window, then the overcurrent cut
  task automatic test_band_windows();
    set_regs(1'b1, 8'd1, 16'd1000, 16'd0);
    send_tick(12'd0, 12'd0);
    send_tick(12'd149, 12'd209);
    send_tick(12'd149, 12'd231);
    send_tick(12'd150, 12'd299);
    send_tick(12'd249, 12'd321);
    send_tick(12'd250, 12'd339);
    send_tick(12'd4095, 12'd361);
    send_tick(12'd4095, 12'd4095);
    send_tick(12'd0, 12'd601);
    send_tick(12'd0, 12'd600);
  endtask

  // Reload while off, saturation at the top, duty above its limit
  task automatic test_duty_limits();
    set_regs(1'b0, 8'd0, 16'd65535, 16'd65535);
    send_tick(12'd0, 12'd0);
    set_regs(1'b1, 8'd0, 16'd65535, 16'd65535);
    send_tick(12'd0, 12'd0);
    set_regs(1'b1, 8'd0, 16'd5, 16'd0);
    send_tick(12'd0, 12'd0);
    send_tick(12'd0, 12'd4095);
  endtask

  // Period lowered below the running count fires on the next tick
  task automatic test_period_change();
    set_regs(1'b1, 8'd200, 16'd1000, 16'd0);
    repeat (3) send_tick(12'd100, 12'd100);
    set_regs(1'b1, 8'd1, 16'd1000, 16'd0);
    repeat (2) send_tick(12'd100, 12'd100);
  endtask

  // Writes to indexes past the register list change nothing
  task automatic test_unused_index();
    wait_idle();
    write_reg(bcpr_pkg::CfgIdxBits'($urandom_range(4, 255)), bcpr_pkg::CfgDatBits'($urandom));
    write_reg(8'd255, 16'hFFFF);
    cfg_valid <= 1'b0;
    repeat (2) send_tick(12'd0, 12'd0);
  endtask

  // Random phases over a spread of register settings
  task automatic test_random_regulation();
    logic                            en;
    logic [bcpr_pkg::PeriodBits-1:0] per;
    logic [bcpr_pkg::DutyBits-1:0]   dmax, dinit;
    int unsigned                     r;
    bcpr_pkg::in_item_t              t;
    for (int p = 0; p < RandPhases; p++) begin
      en = ($urandom_range(0, 9) != 0);
      r  = $urandom_range(0, 99);
      if (r < 50)      per = bcpr_pkg::PeriodBits'($urandom_range(0, 3));
      else if (r < 80) per = bcpr_pkg::PeriodBits'($urandom_range(4, 12));
      else if (r < 95) per = bcpr_pkg::PeriodBits'($urandom_range(13, 60));
      else             per = bcpr_pkg::PeriodBits'($urandom_range(254, 255));
      r = $urandom_range(0, 99);
      if (r < 40)      dmax = bcpr_pkg::DutyBits'($urandom_range(1, 20));
      else if (r < 55) dmax = 16'd0;
      else if (r < 70) dmax = 16'hFFFF;
      else             dmax = bcpr_pkg::DutyBits'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40)      dinit = bcpr_pkg::DutyBits'($urandom_range(0, 25));
      else if (r < 55) dinit = dmax;
      else if (r < 70) dinit = 16'hFFFF;
      else             dinit = bcpr_pkg::DutyBits'($urandom);
      set_regs(en, per, dmax, dinit);
      // every fourth phase runs back to back on both sides
      in_gaps_on    = (p % 4 != 1);
      out_stalls_on = (p % 4 != 1);
      for (int k = 0; k < TicksPerPhase; k++) begin
        t = pick_tick();
        send_tick(t.volt_sample, t.amp_sample);
      end
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_band_windows();
    test_duty_limits();
    test_period_change();
    test_unused_index();
    test_random_regulation();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && regulator_out_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
